// ----- sv/cmc_pkg.sv -----
// Shared types, widths and codes for the colour match centroid block.
package cmc_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned DIST_W   = 10;
  localparam int unsigned COUNT_W  = 23;
  localparam int unsigned SUM_W    = 34;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIMIT_W;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;
  // Wide enough to hold the parameter range limit of 8192.
  localparam int unsigned BOUND_W = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(150);
  localparam logic [COUNT_W-1:0] COUNT_FULL  = {COUNT_W{1'b1}};

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } in_word_t;

  typedef struct packed {
    logic               pixel_match;
    logic               frame_done;
    logic               found;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X_GO,
    ST_DIV_X_WAIT,
    ST_DIV_Y_GO,
    ST_DIV_Y_WAIT
  } cmc_state_t;

  function automatic logic [CHAN_W:0] abs_diff(input logic [CHAN_W-1:0] a,
                                               input logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] d;
    d = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, b} - {1'b0, a});
    return d;
  endfunction

endpackage

// ----- sv/cmc_div.sv -----
// Shared restoring divider, one quotient bit per cycle, quotient known to fit COORD_W.
module cmc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [cmc_pkg::SUM_W-1:0]       dividend,
  input  logic [cmc_pkg::COUNT_W-1:0]     divisor,
  output logic                            done,
  output logic [cmc_pkg::COORD_W-1:0]     quotient
);
  import cmc_pkg::*;

  localparam int unsigned STEP_W = $clog2(COORD_W + 1);

  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COORD_W-1:0] lo_r, lo_nxt;
  logic [COORD_W-1:0] quo_r, quo_nxt;
  logic [COUNT_W-1:0] dvs_r, dvs_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [COUNT_W:0]   trial;
  logic               fits;

  // Partial remainder stays below the divisor, so it fits COUNT_W bits.
  assign trial = {rem_r, lo_r[COORD_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = dividend[SUM_W-1:COORD_W];
      lo_nxt   = dividend[COORD_W-1:0];
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(COORD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? COUNT_W'(trial - {1'b0, dvs_r}) : trial[COUNT_W-1:0];
      lo_nxt   = {lo_r[COORD_W-2:0], 1'b0};
      quo_nxt  = {quo_r[COORD_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/color_match_centroid.sv -----
// An ordinary pixel lands in the output register at the edge that takes it and can leave
// in the next cycle. A frame_end pixel with matches lands once the sequencer has run
// through DIV_X_GO, DIV_X_WAIT, DIV_Y_GO and DIV_Y_WAIT: two 11-bit quotients from one
// shared restoring divider, one bit per cycle, each with a start and a done step, plus hand-over steps.
// Throughput: one pixel per cycle within a frame while the output is not stalled; a frame_end
// with matches holds input off until both quotients are in. Reset (rst_n low, synchronous):
// targets 0, limit 150, accumulators and sequencer cleared, output word dropped.
module color_match_centroid #(
  parameter int unsigned MAX_WIDTH  = cmc_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = cmc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cmc_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cmc_pkg::out_word_t            out_word,
  input  logic                          cfg_we,
  input  logic [cmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cmc_pkg::*;

  localparam logic [BOUND_W-1:0] WIDTH_B  = BOUND_W'(MAX_WIDTH);
  localparam logic [BOUND_W-1:0] HEIGHT_B = BOUND_W'(MAX_HEIGHT);

  // Configuration registers
  logic [CHAN_W-1:0]  tgt_blue_r, tgt_green_r, tgt_red_r;
  logic [LIMIT_W-1:0] limit_r;

  // Frame accumulators
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   col_sum_r, col_sum_nxt;
  logic [SUM_W-1:0]   row_sum_r, row_sum_nxt;

  // Sequencer and output stage
  cmc_state_t         state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;
  logic               match_r, match_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt;

  // Divider hookup
  logic               div_start;
  logic [SUM_W-1:0]   div_dividend;
  logic               div_done;
  logic [COORD_W-1:0] div_quotient;

  logic               in_take;
  logic [DIST_W-1:0]  pix_dist;
  logic               in_frame;
  logic               match;
  logic               add_en;

  // Take a word only when idle and the output register will be free after this edge.
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;

  // L1 colour distance, at most 765, so ten bits.
  assign pix_dist = DIST_W'(abs_diff(in_word.blue, tgt_blue_r))
                  + DIST_W'(abs_diff(in_word.green, tgt_green_r))
                  + DIST_W'(abs_diff(in_word.red, tgt_red_r));

  assign in_frame = (BOUND_W'(in_word.column) < WIDTH_B)
                 && (BOUND_W'(in_word.row) < HEIGHT_B);
  assign match    = in_frame && (pix_dist < limit_r);
  // Saturate: once the count is full, report matches but stop accumulating.
  assign add_en = match && (count_r != COUNT_FULL);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    col_sum_nxt   = col_sum_r;
    row_sum_nxt   = row_sum_r;
    match_nxt     = match_r;
    cx_nxt        = cx_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    div_dividend  = col_sum_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          if (add_en) begin
            count_nxt   = count_r + COUNT_W'(1);
            col_sum_nxt = col_sum_r + SUM_W'(in_word.column);
            row_sum_nxt = row_sum_r + SUM_W'(in_word.row);
          end
          out_word_nxt             = '0;
          out_word_nxt.pixel_match = match;
          out_word_nxt.frame_done  = in_word.frame_end;
          if (!in_word.frame_end) begin
            out_valid_nxt = 1'b1;
          end else if (count_nxt == '0) begin
            // Empty frame: report found=0 at once, nothing to clear.
            out_valid_nxt = 1'b1;
          end else begin
            // Hold the match bit until both quotients are in.
            match_nxt = match;
            state_nxt = ST_DIV_X_GO;
          end
        end
      end
      ST_DIV_X_GO: begin
        div_start    = 1'b1;
        div_dividend = col_sum_r;
        state_nxt    = ST_DIV_X_WAIT;
      end
      ST_DIV_X_WAIT: begin
        if (div_done) begin
          cx_nxt    = div_quotient;
          state_nxt = ST_DIV_Y_GO;
        end
      end
      ST_DIV_Y_GO: begin
        div_start    = 1'b1;
        div_dividend = row_sum_r;
        state_nxt    = ST_DIV_Y_WAIT;
      end
      ST_DIV_Y_WAIT: begin
        if (div_done) begin
          // Output register was freed when the frame_end word went in.
          out_valid_nxt            = 1'b1;
          out_word_nxt.pixel_match = match_r;
          out_word_nxt.frame_done  = 1'b1;
          out_word_nxt.found       = 1'b1;
          out_word_nxt.center_x    = cx_r;
          out_word_nxt.center_y    = div_quotient;
          count_nxt                = '0;
          col_sum_nxt              = '0;
          row_sum_nxt              = '0;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // An empty end of frame still clears the (already zero) count and the sums.
    if (state_r == ST_IDLE && in_take && in_word.frame_end && count_nxt == '0) begin
      col_sum_nxt = '0;
      row_sum_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      col_sum_r   <= '0;
      row_sum_r   <= '0;
      tgt_blue_r  <= '0;
      tgt_green_r <= '0;
      tgt_red_r   <= '0;
      limit_r     <= LIMIT_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      col_sum_r   <= col_sum_nxt;
      row_sum_r   <= row_sum_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_BLUE:    tgt_blue_r  <= cfg_data[CHAN_W-1:0];
          REG_TARGET_GREEN:   tgt_green_r <= cfg_data[CHAN_W-1:0];
          REG_TARGET_RED:     tgt_red_r   <= cfg_data[CHAN_W-1:0];
          REG_DISTANCE_LIMIT: limit_r     <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    out_word_r <= out_word_nxt;
    match_r    <= match_nxt;
    cx_r       <= cx_nxt;
  end

  cmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Input must be held off for the whole division.
  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while the divider sequence runs");

  // Divider finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV_X_WAIT || state_r == ST_DIV_Y_WAIT))
    else $error("divider result with no one waiting");

  // A centroid is only ever reported on the last pixel of a frame.
  a_found_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.found) |-> out_word_r.frame_done)
    else $error("found set on a word that does not end a frame");

  // Accumulators are empty once a frame has been reported.
  a_cleared_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_Y_WAIT && div_done) |=> (count_r == '0 && state_r == ST_IDLE))
    else $error("accumulators not cleared after the centroid");

endmodule
